// File: hdl/dfs_topological_sort_core_defines.svh
// assertion macros for the core file, which checks itself
`ifndef DFS_TOPOLOGICAL_SORT_CORE_DEFINES_SVH
`define DFS_TOPOLOGICAL_SORT_CORE_DEFINES_SVH

// condition implies consequence in the same cycle
`define DTS_ASSERT_NOW(lbl, clk, rst, cond, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error("dfs core check failed");

// condition implies consequence in the next cycle
`define DTS_ASSERT_NEXT(lbl, clk, rst, cond, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error("dfs core check failed");

`endif

// File: hdl/dfs_ts_pkg.sv
package dfs_ts_pkg;
  typedef logic [4:0] vertex_t;
  typedef logic [1:0] status_t;
  typedef logic [1:0] color_t;

  localparam status_t STATUS_ORDERED = 2'd0;
  localparam status_t STATUS_CYCLE   = 2'd1;
  localparam status_t STATUS_DROPPED = 2'd2;

  localparam color_t COLOR_WHITE = 2'd0;
  localparam color_t COLOR_GREY  = 2'd1;
  localparam color_t COLOR_BLACK = 2'd2;

  localparam logic OP_ADD_EDGE = 1'b0;
  localparam logic OP_RUN      = 1'b1;

  localparam int VERTEX_LIMIT = 32;
endpackage

// File: hdl/dfs_ts_if.sv
interface dfs_ts_in_if import dfs_ts_pkg::*; ();
  logic    valid;
  logic    ready;
  logic    opcode;
  vertex_t head_vertex;
  vertex_t tail_vertex;
  modport source (output valid, output opcode, output head_vertex, output tail_vertex,
                  input ready);
  modport sink (input valid, input opcode, input head_vertex, input tail_vertex,
                output ready);
endinterface

interface dfs_ts_out_if import dfs_ts_pkg::*; ();
  logic    valid;
  logic    ready;
  status_t status;
  vertex_t vertex;
  logic    last;
  modport source (output valid, output status, output vertex, output last, input ready);
  modport sink (input valid, input status, input vertex, input last, output ready);
endinterface

// File: hdl/dfs_ts_ram.sv
module dfs_ts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: hdl/dfs_topological_sort_core.sv
// edge add: one transaction per cycle while idle, written straight into the edge memory unless dropped
// run: walks the graph, scanning every stored edge for each vertex visited (read, then check),
//   finishing each vertex and probing each root; the edge memory read is registered
// results: ordered vertices read from the finish-order memory (read, then load), through an output register
// reset (rst, synchronous): vertex count 32, edge store empty, all vertices white
module dfs_topological_sort_core import dfs_ts_pkg::*; #(
  parameter int MAX_VERTICES = 32,
  parameter int MAX_EDGES    = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [5:0]  cfg_data,
  dfs_ts_in_if.sink   items,
  dfs_ts_out_if.source results
);
`include "dfs_topological_sort_core_defines.svh"

  // derived sizes
  localparam int VCAP = (MAX_VERTICES < VERTEX_LIMIT) ? MAX_VERTICES : VERTEX_LIMIT;
  localparam int VIW  = $clog2(VCAP);
  localparam int EAW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int KW   = $clog2(MAX_EDGES + 1);
  localparam int SAW  = $clog2(MAX_VERTICES);
  localparam int SPW  = $clog2(MAX_VERTICES + 1);
  localparam int SW   = 5 + KW;

  // sequencer states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_ROOT   = 4'd1;
  localparam logic [3:0] S_EREAD  = 4'd2;
  localparam logic [3:0] S_ECHK   = 4'd3;
  localparam logic [3:0] S_POP    = 4'd4;
  localparam logic [3:0] S_EMITRD = 4'd5;
  localparam logic [3:0] S_EMITLD = 4'd6;
  localparam logic [3:0] S_FAIL   = 4'd7;
  localparam logic [3:0] S_ERR    = 4'd8;

  logic [3:0]     state;
  logic [5:0]     node_count;
  logic [KW-1:0]  edge_fill;
  logic           edge_error;
  color_t         color [VCAP];
  logic [5:0]     root;
  vertex_t        cur_v;
  logic [KW-1:0]  cur_k;
  logic [SPW-1:0] sp;
  logic [5:0]     done;
  logic [5:0]     emit_idx;

  logic           out_valid;
  status_t        out_status;
  vertex_t        out_vertex;
  logic           out_last;

  // effective vertex count, saturated to 1 .. VCAP
  logic [5:0] n;
  always_comb begin
    if (node_count == 6'd0) begin
      n = 6'd1;
    end else if (node_count > 6'(VCAP)) begin
      n = 6'(VCAP);
    end else begin
      n = node_count;
    end
  end

  logic in_fire, add_fire, run_fire, out_free;
  assign items.ready = (state == S_IDLE);
  assign in_fire     = items.valid && items.ready;
  assign add_fire    = in_fire && (items.opcode == OP_ADD_EDGE);
  assign run_fire    = in_fire && (items.opcode == OP_RUN);
  assign out_free    = !out_valid || results.ready;

  // edge drop check against the count in force right now
  logic add_drop;
  assign add_drop = (edge_fill >= KW'(MAX_EDGES)) || ({1'b0, items.head_vertex} >= n) ||
                    ({1'b0, items.tail_vertex} >= n);

  // edge memory: written on an edge add that is not dropped, read at the scan pointer
  logic [9:0] edge_rdata;
  dfs_ts_ram #(.WIDTH(10), .DEPTH(MAX_EDGES)) u_edge_ram (
    .clk   (clk),
    .we    (add_fire && !add_drop),
    .waddr (edge_fill[EAW-1:0]),
    .wdata ({items.head_vertex, items.tail_vertex}),
    .raddr (cur_k[EAW-1:0]),
    .rdata (edge_rdata)
  );

  vertex_t e_head, e_tail;
  logic [KW-1:0] k_next;
  assign e_head = edge_rdata[9:5];
  assign e_tail = edge_rdata[4:0];
  assign k_next = cur_k + KW'(1);

  // color lookup: root probe or edge target, never both in one cycle
  logic [VIW-1:0] caddr;
  color_t         ccol;
  assign caddr = (state == S_ROOT) ? root[VIW-1:0] : e_tail[VIW-1:0];
  assign ccol  = color[caddr];

  logic edge_valid;
  assign edge_valid = (e_head == cur_v) && ({1'b0, e_tail} < n);

  logic do_push, do_finish;
  assign do_push   = (state == S_ECHK) && edge_valid && (ccol == COLOR_WHITE);
  assign do_finish = (state == S_EREAD) && (cur_k >= edge_fill);

  // stack of suspended parents; the top of the search lives in cur_v / cur_k
  logic [SW-1:0]  stack_rdata;
  logic [SPW-1:0] sp_m1, sp_m2;
  assign sp_m1 = sp - SPW'(1);
  assign sp_m2 = sp - SPW'(2);
  dfs_ts_ram #(.WIDTH(SW), .DEPTH(MAX_VERTICES)) u_stack_ram (
    .clk   (clk),
    .we    (do_push && (sp < SPW'(MAX_VERTICES))),
    .waddr (sp_m1[SAW-1:0]),
    .wdata ({cur_v, k_next}),
    .raddr (sp_m2[SAW-1:0]),
    .rdata (stack_rdata)
  );

  // postorder record, read back in reverse
  vertex_t    finish_rdata;
  logic [5:0] emit_addr;
  assign emit_addr = n - 6'd1 - emit_idx;
  dfs_ts_ram #(.WIDTH(5), .DEPTH(MAX_VERTICES)) u_finish_ram (
    .clk   (clk),
    .we    (do_finish && (done < 6'(MAX_VERTICES))),
    .waddr (done[SAW-1:0]),
    .wdata (cur_v),
    .raddr (emit_addr[SAW-1:0]),
    .rdata (finish_rdata)
  );

  // end of run: the store, error flag and colors all go back to empty
  logic run_clear;
  always_comb begin
    run_clear = 1'b0;
    case (state)
      S_ERR, S_FAIL: run_clear = out_free;
      S_EMITLD:      run_clear = (emit_idx == n - 6'd1);
      default:       run_clear = 1'b0;
    endcase
  end

  // config register and edge bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= 6'd32;
      edge_fill  <= '0;
      edge_error <= 1'b0;
    end else begin
      if (cfg_write) begin
        node_count <= cfg_data;
      end
      if (run_clear) begin
        edge_fill  <= '0;
        edge_error <= 1'b0;
      end else if (add_fire) begin
        if (add_drop) begin
          edge_error <= 1'b1;
        end else begin
          edge_fill <= edge_fill + KW'(1);
        end
      end
    end
  end

  // vertex colors in flops, cleared together
  always_ff @(posedge clk) begin
    if (rst || run_clear) begin
      for (int i = 0; i < VCAP; i++) begin
        color[i] <= COLOR_WHITE;
      end
    end else begin
      if ((state == S_ROOT) && (root < n) && (ccol == COLOR_WHITE)) begin
        color[caddr] <= COLOR_GREY;
      end
      if (do_push) begin
        color[caddr] <= COLOR_GREY;
      end
      if (do_finish) begin
        color[cur_v[VIW-1:0]] <= COLOR_BLACK;
      end
    end
  end

  // output register loads on an emit or a single-result end of run
  logic out_load;
  assign out_load = (state == S_EMITLD) ||
                    (((state == S_FAIL) || (state == S_ERR)) && out_free);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  // search sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (run_fire) begin
            root  <= '0;
            done  <= '0;
            state <= edge_error ? S_ERR : S_ROOT;
          end
        end
        S_ROOT: begin
          if (root >= n) begin
            emit_idx <= '0;
            state    <= (done == n) ? S_EMITRD : S_FAIL;
          end else if (ccol == COLOR_WHITE) begin
            cur_v <= root[4:0];
            cur_k <= '0;
            sp    <= SPW'(1);
            state <= S_EREAD;
          end else begin
            root <= root + 6'd1;
          end
        end
        S_EREAD: begin
          if (do_finish) begin
            done <= done + 6'd1;
            sp   <= sp_m1;
            if (sp == SPW'(1)) begin
              root  <= root + 6'd1;
              state <= S_ROOT;
            end else begin
              state <= S_POP;
            end
          end else begin
            state <= S_ECHK;
          end
        end
        S_ECHK: begin
          // grey target (self loop included) ends the run with a cycle result
          if (edge_valid && (ccol == COLOR_GREY)) begin
            state <= S_FAIL;
          end else if (do_push && (sp < SPW'(MAX_VERTICES))) begin
            cur_v <= e_tail;
            cur_k <= '0;
            sp    <= sp + SPW'(1);
            state <= S_EREAD;
          end else begin
            cur_k <= k_next;
            state <= S_EREAD;
          end
        end
        S_POP: begin
          cur_v <= stack_rdata[SW-1:KW];
          cur_k <= stack_rdata[KW-1:0];
          state <= S_EREAD;
        end
        S_EMITRD: begin
          if (out_free) begin
            state <= S_EMITLD;
          end
        end
        S_EMITLD: begin
          // output register is empty here: it was free when the read went out
          out_status <= STATUS_ORDERED;
          out_vertex <= finish_rdata;
          out_last   <= (emit_idx == n - 6'd1);
          if (emit_idx == n - 6'd1) begin
            state <= S_IDLE;
          end else begin
            emit_idx <= emit_idx + 6'd1;
            state    <= S_EMITRD;
          end
        end
        S_FAIL, S_ERR: begin
          if (out_free) begin
            out_status <= (state == S_ERR) ? STATUS_DROPPED : STATUS_CYCLE;
            out_vertex <= '0;
            out_last   <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign results.valid  = out_valid;
  assign results.status = out_status;
  assign results.vertex = out_vertex;
  assign results.last   = out_last;

  // checks
  `DTS_ASSERT_NOW(a_fill_bound, clk, rst, 1'b1, edge_fill <= KW'(MAX_EDGES))
  `DTS_ASSERT_NOW(a_sp_bound, clk, rst, state == S_EREAD, sp >= SPW'(1) && sp <= n[SPW-1:0])
  `DTS_ASSERT_NOW(a_fail_last, clk, rst, out_valid && out_status != STATUS_ORDERED, out_last)
  `DTS_ASSERT_NEXT(a_run_busy, clk, rst, run_fire, state != S_IDLE)
endmodule
